/* design/piwa_pkg.sv */
// Shared types, codes and constants of the pulse interval window average block.
package piwa_pkg;

   localparam int SAMPLE_DEPTH_DEF = 8;

   localparam int TIME_W   = 32;
   localparam int VALUE_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int TAG_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SAMPLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_KIND = 2'd2;

   // Reset values of the registers.
   localparam logic [VALUE_W-1:0]  MAX_SAMPLE_RST = 8'd255;
   localparam logic [WINDOW_W-1:0] WINDOW_MS_RST  = 16'd1000;
   localparam logic [TAG_W-1:0]    EVENT_KIND_RST = 8'd0;

   // Operation codes carried in the request side-band.
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0]  max_sample;
      logic [WINDOW_W-1:0] window_ms;
      logic [TAG_W-1:0]    event_kind;
   } piwa_cfg_type;

   typedef struct packed {
      logic load;       // capture the incoming word
      logic edge_upd;   // shift edge timestamps
      logic consume;    // mark the latest edge as handled
      logic store;      // write the sample into the ring, clear the sums
      logic read;       // read one ring slot
      logic div_start;  // load the divider
      logic div_step;   // one divider iteration
      logic emit;       // load the result register
   } piwa_cmd_type;

   typedef struct packed {
      logic is_edge;
      logic new_edge;
      logic keep;
      logic last_read;
      logic div_last;
      logic out_free;
   } piwa_status_type;

endpackage

/* design/pulse_interval_window_average.sv */
// Top level of the pulse interval window average block: configuration and wiring.
//
//  Channel   Direction  Handshake             Payload
//  req       in         req_tvalid/tready     tuser: operation; tdata: timestamp_ms
//  rsp       out        rsp_tvalid/tready     tuser: kind_tag; tdata: average_interval
//  csr       in         csr_we (no wait)      csr_index, csr_wdata
//
// An edge word, or a poll that finds no new edge or rejects its interval, goes from the
// decide state back to idle. A storing poll walks the ring one slot a cycle, then a
// restoring divider gives one bit of the mean a cycle, SUM_W in all, SUM_W being 8 plus
// the bits of the slot count. Reset clears the edge times, the write slot and the
// per-slot written flags; words are taken in the cycle after reset is released. A result
// waits in the output register while a new word is taken; only a later result stalls on it.
module pulse_interval_window_average #(
   parameter int SAMPLE_DEPTH = piwa_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [piwa_pkg::REQ_DATA_W-1:0]     req_tdata,   // [31:0] timestamp_ms
   input  logic [piwa_pkg::REQ_USER_W-1:0]     req_tuser,   // [0] operation
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [piwa_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] average_interval
   output logic [piwa_pkg::RSP_USER_W-1:0]     rsp_tuser,   // [7:0] kind_tag
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [piwa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [piwa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import piwa_pkg::*;

   piwa_cfg_type    cfg_ff;
   piwa_cmd_type    cmd;
   piwa_status_type status;

   // Configuration registers. Writes to an index beyond the list are ignored.
   // Each register keeps the low bits of the write data that fit its width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_sample <= MAX_SAMPLE_RST;
         cfg_ff.window_ms  <= WINDOW_MS_RST;
         cfg_ff.event_kind <= EVENT_KIND_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_SAMPLE: cfg_ff.max_sample <= csr_wdata[VALUE_W-1:0];
            CSR_WINDOW_MS:  cfg_ff.window_ms  <= csr_wdata[WINDOW_W-1:0];
            CSR_EVENT_KIND: cfg_ff.event_kind <= csr_wdata[TAG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The controller decides what happens to each accepted word and steps the
   // datapath through the ring walk and the division.
   piwa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the edge times, the sample ring, the windowed sum and
   // count, the divider and the output register.
   piwa_dp #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* design/piwa_ctrl.sv */
// Controller state machine sequencing the ring walk and the division.
module piwa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  piwa_pkg::piwa_status_type  status,
   output piwa_pkg::piwa_cmd_type     cmd
);
   import piwa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_edge) begin
               cmd.edge_upd = 1'b1;
               state_in     = ST_IDLE;
            end else if (!status.new_edge) begin
               state_in = ST_IDLE;
            end else begin
               cmd.consume = 1'b1;
               if (status.keep) begin
                  cmd.store = 1'b1;
                  state_in  = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            cmd.read = 1'b1;
            if (status.last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/piwa_dp.sv */
// Datapath: edge timestamps, sample ring, windowed accumulator and serial divider.
module piwa_dp #(
   parameter int SAMPLE_DEPTH = piwa_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  piwa_pkg::piwa_cfg_type              cfg,
   input  logic [piwa_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic [piwa_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [piwa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [piwa_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  piwa_pkg::piwa_cmd_type              cmd,
   output piwa_pkg::piwa_status_type           status
);
   import piwa_pkg::*;

   localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
   localparam int SUM_W = VALUE_W + CNT_W;
   localparam int DCW   = $clog2(SUM_W);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_DEPTH - 1);

   // Captured request word.
   logic                op_ff;
   logic [TIME_W-1:0]   ts_ff;

   // Edge bookkeeping.
   logic [TIME_W-1:0]   latest_ff;
   logic [TIME_W-1:0]   prior_ff;
   logic [TIME_W-1:0]   handled_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic [IDX_W-1:0]    slot_in;

   // Sample ring: data in a memory, written-flags in flip-flops.
   logic [VALUE_W-1:0]  ring_val [SAMPLE_DEPTH];
   logic [TIME_W-1:0]   ring_time [SAMPLE_DEPTH];
   logic [SAMPLE_DEPTH-1:0] valid_ff;

   // Walk and accumulation.
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [VALUE_W-1:0]  rd_val_ff;
   logic [TIME_W-1:0]   rd_time_ff;
   logic                rd_ok_ff;
   logic                rd_live_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]    cnt_ff;

   // Divider.
   logic [SUM_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [DCW-1:0]      div_cnt_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [TIME_W-1:0]   interval;
   logic [TIME_W-1:0]   age;
   logic [VALUE_W-1:0]  eff_val;
   logic [TIME_W-1:0]   eff_time;
   logic                in_window;
   logic [CNT_W:0]      rem_sh;
   logic                rem_ge;

   assign interval = latest_ff - prior_ff;
   assign slot_in  = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;

   // A slot never written reads as a value and time of zero.
   assign eff_val   = rd_ok_ff ? rd_val_ff : '0;
   assign eff_time  = rd_ok_ff ? rd_time_ff : '0;
   assign age       = handled_ff - eff_time;
   assign in_window = (age <= {{(TIME_W-WINDOW_W){1'b0}}, cfg.window_ms});

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, cnt_ff});

   assign status.is_edge   = (op_ff == OP_EDGE);
   assign status.new_edge  = (latest_ff != handled_ff);
   assign status.keep      = (interval != '0) &&
                             (interval <= {{(TIME_W-VALUE_W){1'b0}}, cfg.max_sample});
   assign status.last_read = (rd_idx_ff == LAST_IDX);
   assign status.div_last  = (div_cnt_ff == DCW'(SUM_W - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ring_val[slot_ff]  <= interval[VALUE_W-1:0];
         ring_time[slot_ff] <= latest_ff;
      end
      rd_val_ff  <= ring_val[rd_idx_ff];
      rd_time_ff <= ring_time[rd_idx_ff];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ok_ff <= valid_ff[rd_idx_ff];
      if (cmd.load) begin
         op_ff <= req_tuser[0];
         ts_ff <= req_tdata;
      end
      if (cmd.emit) begin
         rsp_data_ff <= quo_ff[RSP_DATA_W-1:0];
         rsp_user_ff <= cfg.event_kind;
      end
      if (cmd.div_start) begin
         quo_ff     <= sum_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff     <= rem_ge ? CNT_W'(rem_sh - {1'b0, cnt_ff}) : rem_sh[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Control state and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff    <= '0;
         prior_ff     <= '0;
         handled_ff   <= '0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_live_ff   <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.edge_upd) begin
            prior_ff  <= latest_ff;
            latest_ff <= ts_ff;
         end
         if (cmd.consume) begin
            handled_ff <= latest_ff;
         end
         rd_live_ff <= cmd.read;
         if (cmd.store) begin
            valid_ff[slot_ff] <= 1'b1;
            slot_ff   <= slot_in;
            rd_idx_ff <= '0;
            sum_ff    <= '0;
            cnt_ff    <= '0;
         end else begin
            if (cmd.read) begin
               rd_idx_ff <= (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
            end
            if (rd_live_ff && in_window) begin
               sum_ff <= sum_ff + SUM_W'(eff_val);
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_store_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> (sum_ff == '0) && (cnt_ff == '0) && valid_ff[$past(slot_ff)])
      else $error("ring store did not clear the accumulator or mark the slot");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (cnt_ff != '0))
      else $error("division started with an empty sample count");

   a_mean_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (quo_ff[SUM_W-1:RSP_DATA_W] == '0))
      else $error("mean does not fit the result field");

   a_edge_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_upd |=> (prior_ff == $past(latest_ff)) && (latest_ff == $past(ts_ff)))
      else $error("edge timestamps not shifted");
`endif

endmodule

/* tb/sv/tb_pulse_interval_window_average.sv */
// Self-checking testbench of the pulse interval window average block.
module tb_pulse_interval_window_average;
   timeunit 1ns;
   timeprecision 1ps;

   import piwa_pkg::*;

   localparam int RING_DEPTH    = SAMPLE_DEPTH_DEF;
   localparam int GAP_MAX       = 17;
   localparam int LONG_HOLD     = 400;
   // This leaves the block well clear of any storing poll or other word still in flight
   // before a register is touched or the run is closed.
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 140;
   // A limit well above the length of the slowest correct run.
   localparam int CYCLE_LIMIT   = 400000;

   // One expected result word: the tag and the windowed mean.
   typedef struct {
      logic [TAG_W-1:0]   tag;
      logic [VALUE_W-1:0] mean;
   } speed_word_type;

   // Scoreboard: keeps its own copy of the edge times, the sample ring and the
   // registers, works out the mean for every storing poll and matches results.
   class interval_average_board;
      logic [VALUE_W-1:0]  max_sample;
      logic [WINDOW_W-1:0] window_ms;
      logic [TAG_W-1:0]    event_kind;
      logic [TIME_W-1:0]   newest_edge;
      logic [TIME_W-1:0]   older_edge;
      logic [TIME_W-1:0]   handled_edge;
      logic [VALUE_W-1:0]  ring_value [RING_DEPTH];
      logic [TIME_W-1:0]   ring_stamp [RING_DEPTH];
      int unsigned         write_slot;
      speed_word_type      pending_means [$];
      int                  faults;
      int                  means_checked;
      int                  words_taken;

      function new();
         max_sample   = MAX_SAMPLE_RST;
         window_ms    = WINDOW_MS_RST;
         event_kind   = EVENT_KIND_RST;
         newest_edge  = '0;
         older_edge   = '0;
         handled_edge = '0;
         write_slot   = 0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_value[i] = '0;
            ring_stamp[i] = '0;
         end
         faults        = 0;
         means_checked = 0;
         words_taken   = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MAX_SAMPLE: max_sample = value[VALUE_W-1:0];
            CSR_WINDOW_MS:  window_ms  = value[WINDOW_W-1:0];
            CSR_EVENT_KIND: event_kind = value[TAG_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_request(logic op, logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0] span;
         logic [TIME_W-1:0] age;
         logic [31:0]       total;
         int unsigned       counted;
         speed_word_type    want;
         words_taken++;
         if (op == OP_EDGE) begin
            older_edge  = newest_edge;
            newest_edge = stamp;
            return;
         end
         if (newest_edge == handled_edge)
            return;
         handled_edge = newest_edge;
         span = newest_edge - older_edge;
         if (span == 0 || span > max_sample)
            return;
         ring_value[write_slot] = span[VALUE_W-1:0];
         ring_stamp[write_slot] = handled_edge;
         total   = 0;
         counted = 0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            age = handled_edge - ring_stamp[i];
            if (age <= window_ms) begin
               total += ring_value[i];
               counted++;
            end
         end
         write_slot = (write_slot + 1) % RING_DEPTH;
         want.tag  = event_kind;
         want.mean = VALUE_W'(total / counted);
         pending_means.push_back(want);
      endfunction

      task report(string what);
         faults++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task match_result(logic [TAG_W-1:0] tag_seen, logic [VALUE_W-1:0] mean_seen);
         speed_word_type want;
         if (pending_means.size() == 0) begin
            report($sformatf("unexpected result, tag %0d mean %0d", tag_seen, mean_seen));
            return;
         end
         want = pending_means.pop_front();
         means_checked++;
         if (tag_seen !== want.tag)
            report($sformatf("kind_tag %0d, expected %0d", tag_seen, want.tag));
         if (mean_seen !== want.mean)
            report($sformatf("average_interval %0d, expected %0d", mean_seen, want.mean));
      endtask

      task flush_leftovers();
         speed_word_type want;
         while (pending_means.size() != 0) begin
            want = pending_means.pop_front();
            report($sformatf("result never arrived, tag %0d mean %0d", want.tag, want.mean));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   interval_average_board board = new();

   // Simulated millisecond clock of the wheel, and the idling modes of both sides.
   logic [TIME_W-1:0] wheel_ms = '0;
   bit                tx_calm = 1'b0;
   bit                rx_calm = 1'b0;
   bit                hold_pending = 1'b0;
   int                settings_used = 1;
   int                cycle_count = 0;

   pulse_interval_window_average u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] timestamp_ms
      .req_tuser  (req_tuser),    // [0] operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] average_interval
      .rsp_tuser  (rsp_tuser),    // [7:0] kind_tag
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Every so often a side switches between random idling and a stretch with none,
   // so that back-to-back words are seen as well as gaps on every phase of the work.
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 29) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Intervals mostly fall inside the accepted range, with zero, the limit itself
   // and values just above it mixed in so that rejections happen regularly.
   function automatic logic [TIME_W-1:0] draw_interval();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0:       return '0;
         1:       return TIME_W'(board.max_sample) + $urandom_range(1, 40);
         2:       return TIME_W'(board.max_sample);
         3:       return $urandom_range(256, 5000);
         default: return $urandom_range(1, board.max_sample);
      endcase
   endfunction

   // Offers one word and returns at the rising edge where it is taken. The valid
   // stays high into the next call when no gap is drawn.
   task automatic send_word(logic op, logic [TIME_W-1:0] stamp);
      int gap;
      gap = draw_gap(tx_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= stamp;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.take_request(op, stamp);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_register(index, value);
   endtask

   // Stops offering words, waits for every expected mean and then lets the block
   // finish any poll or edge that leaves no result behind.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic edge_at(logic [TIME_W-1:0] stamp);
      send_word(OP_EDGE, stamp);
   endtask

   task automatic poll_now();
      send_word(OP_POLL, $urandom());
   endtask

   // Random traffic: mostly an edge followed by a poll, as the wheel would give,
   // with doubled edges, idle polls and jumps of the clock as noise.
   task automatic run_traffic(int budget);
      int sent;
      int pick;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            wheel_ms += draw_interval();
            edge_at(wheel_ms);
            poll_now();
            sent += 2;
         end else if (pick < 85) begin
            wheel_ms += draw_interval();
            edge_at(wheel_ms);
            sent++;
         end else if (pick < 93) begin
            poll_now();
            sent++;
         end else begin
            wheel_ms = $urandom();
            edge_at(wheel_ms);
            sent++;
         end
      end
   endtask

   // Results are sampled at the rising edge where both handshake lines are high.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.match_result(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d means outstanding.",
                  cycle_count, board.pending_means.size());
         $display("pulse_interval_window_average: mismatch");
         $finish;
      end
   end

   // Result side. Normally it idles for a drawn number of cycles before each word;
   // once it holds off for a long stretch so that the output register and the
   // block's last stage fill up and the request side has to stall.
   initial begin : result_sink
      int hold;
      forever begin
         hold = draw_gap(rx_calm);
         if (hold_pending) begin
            hold = LONG_HOLD;
            hold_pending = 1'b0;
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   initial begin : stimulus
      int max_pick;
      int window_pick;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: max_sample 255, window 1000, tag 0.
      poll_now();                      // no edge has come since reset
      edge_at(32'h0000_0000);          // edge equal to the cleared time
      poll_now();                      // still nothing new
      edge_at(32'h0000_0005);
      poll_now();                      // stored; cleared slots pull the mean to zero
      poll_now();                      // same edge again, no result
      edge_at(32'h0000_0009);
      edge_at(32'h0000_0009);
      poll_now();                      // zero interval is consumed without a result
      edge_at(32'h0000_0108);
      poll_now();                      // interval equal to max_sample
      edge_at(32'h0000_0208);
      poll_now();                      // one above max_sample, rejected
      edge_at(32'h0000_0209);
      poll_now();                      // shortest interval
      edge_at(32'hFFFF_FFF0);
      edge_at(32'h0000_000F);
      poll_now();                      // interval across the wrap; slots 0x108, 0x209 age out
      edge_at(32'hFFFF_FFFF);
      poll_now();                      // huge wrapped interval, rejected
      edge_at(32'h0000_0000);
      poll_now();                      // wrap by one millisecond
      settle();

      // Each phase runs under its own settings; the first two are the extremes.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_MAX_SAMPLE, 16'd1);
               write_register(CSR_WINDOW_MS, 16'd0);
               write_register(CSR_EVENT_KIND, 16'd255);
            end
            1: begin
               write_register(CSR_MAX_SAMPLE, 16'd255);
               write_register(CSR_WINDOW_MS, 16'hFFFF);
               write_register(CSR_EVENT_KIND, 16'd0);
            end
            default: begin
               max_pick    = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40)
                                                         : $urandom_range(1, 255);
               window_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1500)
                                                         : $urandom_range(0, 65535);
               write_register(CSR_MAX_SAMPLE, CSR_DATA_W'(max_pick));
               write_register(CSR_WINDOW_MS, CSR_DATA_W'(window_pick));
               write_register(CSR_EVENT_KIND, CSR_DATA_W'($urandom_range(0, 255)));
            end
         endcase
         settings_used++;
         if (phase == 2)
            hold_pending = 1'b1;
         // Some phases run the wheel clock through its wrap.
         if (phase % 2 == 1)
            wheel_ms = 32'hFFFF_FC00 + $urandom_range(0, 255);
         run_traffic(PHASE_WORDS);
         settle();
      end

      board.flush_leftovers();
      $display("Covered %0d request words under %0d register settings, with one long",
               board.words_taken, settings_used);
      $display("result stall; %0d averages compared, %0d faults found.",
               board.means_checked, board.faults);
      if (board.faults == 0)
         $display("pulse_interval_window_average: match");
      else
         $display("pulse_interval_window_average: mismatch");
      $finish;
   end

endmodule
